// File: hw/rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types and constants of the button press classifier
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int unsigned CountWidth = 16;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [CountWidth-1:0] CountMax = '1;

   // reset values of the configuration registers
   localparam logic [CountWidth-1:0] DebounceReset = 16'd50;
   localparam logic [CountWidth-1:0] LongPressReset = 16'd1000;
   localparam logic [CountWidth-1:0] DoubleWindowReset = 16'd500;
   localparam logic PressedLevelReset = 1'b0;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_EDGE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_SINGLE = 2'd0,
      KIND_DOUBLE = 2'd1,
      KIND_LONG   = 2'd2
   } kind_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DEBOUNCE      = 2'd0,
      CSR_LONG_PRESS    = 2'd1,
      CSR_DOUBLE_WINDOW = 2'd2,
      CSR_PRESSED_LEVEL = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CountWidth-1:0] debounce_ms;
      logic [CountWidth-1:0] long_press_ms;
      logic [CountWidth-1:0] double_window_ms;
      logic                  pressed_level;
   } cfg_type;

   typedef struct packed {
      op_type op;
      logic   pin_level;
   } item_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
   } result_type;

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      sat_inc = (v == CountMax) ? v : v + 1'b1;
   endfunction

endpackage

// File: hw/rtl/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier
// sorts the presses of one button into single, double and long presses
// ----------------------------------------------------------------------------
// usage
//   req_ channel: one transaction per item, req_op selects a one-millisecond
//   tick or a pin edge that carries the sampled req_pin_level
//   rsp_ channel: zero or one transaction per item, rsp_press_kind gives
//   single, double or long press
//   csr_ channel: register writes by index (debounce, long press limit,
//   double-press window, pressed level), always ready, only while idle
// timing
//   an item is held in the input register, is classified there and its
//   press, if any, lands in the output register, which drives rsp_valid;
//   the item moves on only when the output slot is free
//   throughput is one item per cycle while the output slot is free; the
//   output register frees the input side once rsp_ready takes its press
// reset
//   configuration returns to 50 / 1000 / 500 ms and pressed level low, all
//   timers, the tally and the window clear, both channels empty
// stall
//   while a press waits on rsp_ and rsp_ready is low, the input register
//   holds its item and req_ready drops once it is full; nothing is lost
// ----------------------------------------------------------------------------
module button_press_classifier (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic                              req_pin_level,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_press_kind,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bpc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [bpc_pkg::CountWidth-1:0]    csr_data
);
   import bpc_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   item_type   item_ff, item_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   kind_type   kind_ff, kind_in;

   cfg_type    cfg;
   result_type result;
   logic       out_free;
   logic       advance;
   logic       req_take;

   // configuration registers, no back-pressure
   assign csr_ready = 1'b1;

   bpc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .write (csr_valid),
      .index (csr_index),
      .data  (csr_data),
      .cfg   (cfg)
   );

   // item leaves the input register once the output slot can take a press
   assign out_free = !out_valid_ff || rsp_ready;
   assign advance  = in_valid_ff && out_free;
   assign req_take = req_valid && req_ready;
   assign req_ready = !in_valid_ff || advance;

   bpc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         item_in.op        = op_type'(req_op);
         item_in.pin_level = req_pin_level;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      kind_in      = kind_ff;
      if (out_free) begin
         out_valid_in = advance && result.valid;
         kind_in      = result.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      kind_ff <= kind_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_press_kind = kind_ff;

endmodule

// File: hw/rtl/bpc_csr.sv
// ----------------------------------------------------------------------------
// bpc_csr
// configuration registers of the button press classifier
// ----------------------------------------------------------------------------
module bpc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             write,
   input  logic [bpc_pkg::CsrIndexWidth-1:0] index,
   input  logic [bpc_pkg::CountWidth-1:0]    data,
   output bpc_pkg::cfg_type                  cfg
);
   import bpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (csr_index_type'(index))
            CSR_DEBOUNCE:      cfg_in.debounce_ms = data;
            CSR_LONG_PRESS:    cfg_in.long_press_ms = data;
            CSR_DOUBLE_WINDOW: cfg_in.double_window_ms = data;
            CSR_PRESSED_LEVEL: cfg_in.pressed_level = data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms      <= DebounceReset;
         cfg_ff.long_press_ms    <= LongPressReset;
         cfg_ff.double_window_ms <= DoubleWindowReset;
         cfg_ff.pressed_level    <= PressedLevelReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/bpc_core.sv
// ----------------------------------------------------------------------------
// bpc_core
// timing state and press classification, one transaction per step
// ----------------------------------------------------------------------------
module bpc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  bpc_pkg::item_type   item,
   input  bpc_pkg::cfg_type    cfg,
   output bpc_pkg::result_type result
);
   import bpc_pkg::*;

   logic [CountWidth-1:0] since_event_ff, since_event_in;
   logic [CountWidth-1:0] since_press_ff, since_press_in;
   logic [CountWidth-1:0] window_left_ff, window_left_in;
   logic                  tally_ff, tally_in;
   logic                  window_open_ff, window_open_in;
   result_type            res;

   always_comb begin
      since_event_in = since_event_ff;
      since_press_in = since_press_ff;
      window_left_in = window_left_ff;
      tally_in       = tally_ff;
      window_open_in = window_open_ff;
      res.valid      = 1'b0;
      res.kind       = KIND_SINGLE;

      if (item.op == OP_TICK) begin
         since_event_in = sat_inc(since_event_ff);
         since_press_in = sat_inc(since_press_ff);
         if (window_open_ff) begin
            // window ran out: lone press
            if (window_left_ff <= CountWidth'(1)) begin
               window_left_in = '0;
               window_open_in = 1'b0;
               tally_in       = 1'b0;
               res.valid      = 1'b1;
               res.kind       = KIND_SINGLE;
            end else begin
               window_left_in = window_left_ff - 1'b1;
            end
         end
      end else if (since_event_ff >= cfg.debounce_ms) begin
         since_event_in = '0;
         if (item.pin_level == cfg.pressed_level) begin
            since_press_in = '0;
         end else if (since_press_ff > cfg.long_press_ms) begin
            // long hold clears the tally but leaves the window running
            tally_in  = 1'b0;
            res.valid = 1'b1;
            res.kind  = KIND_LONG;
         end else if (tally_ff) begin
            tally_in       = 1'b0;
            window_open_in = 1'b0;
            window_left_in = '0;
            res.valid      = 1'b1;
            res.kind       = KIND_DOUBLE;
         end else begin
            tally_in       = 1'b1;
            window_left_in = cfg.double_window_ms;
            window_open_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_event_ff <= '0;
         since_press_ff <= '0;
         window_left_ff <= '0;
         tally_ff       <= 1'b0;
         window_open_ff <= 1'b0;
      end else if (step) begin
         since_event_ff <= since_event_in;
         since_press_ff <= since_press_in;
         window_left_ff <= window_left_in;
         tally_ff       <= tally_in;
         window_open_ff <= window_open_in;
      end
   end

   assign result = res;

endmodule
